// File: hdl/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants for the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Mapper type codes, as written to the mapper_type register
  typedef enum logic [1:0] {
    MAPPER_NONE = 2'd0,
    MAPPER_MBC1 = 2'd1,
    MAPPER_MBC3 = 2'd2,
    MAPPER_MBC5 = 2'd3
  } mapper_t;

  // Bus write regions, decoded from address[15:13]
  typedef enum logic [2:0] {
    REGION_RAM_EN   = 3'd0,   // 0x0000-0x1FFF
    REGION_ROM_LOW  = 3'd1,   // 0x2000-0x3FFF
    REGION_RAM_BANK = 3'd2,   // 0x4000-0x5FFF
    REGION_MODE     = 3'd3,   // 0x6000-0x7FFF
    REGION_OTHER0   = 3'd4,
    REGION_OTHER1   = 3'd5,
    REGION_OTHER2   = 3'd6,
    REGION_OTHER3   = 3'd7
  } region_t;

  // Config port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgAddrW-3:0] CFG_IDX_MAPPER = 1'b0;

  // Constants of the write decode
  localparam logic [3:0] RAM_EN_KEY   = 4'hA;
  localparam logic [7:0] LOW_BANK_RST = 8'h01;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [8:0] rom_bank;
    logic [3:0] ram_bank;
    logic       ram_enabled;
    logic       bank_mode;
  } out_item_t;

endpackage

// File: hdl/cartridge_bank_controller.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// MBC1/MBC3/MBC5 style bank controller: one bus write in, one mapping out.
// ----------------------------------------------------------------------------
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------
//  in        | in_valid / in_stall   | in_item  (address, data)
//  out       | out_valid / out_stall | out_item (rom_bank, ram_bank, ...)
//  cfg (APB) | psel/penable/pready   | paddr, pwrite, pwdata, prdata
//
//  A request is registered in the input register, then moves to the result
//  register; one request per cycle unless out_stall holds the result register.
//  Bank registers update on the input-to-result move, strictly in order.
//  Reset (rst_n, synchronous) empties both stages, sets mapper to none and
//  the low ROM bank to 1.
//  out_stall holds the result register; input accepts until s1 backs up.
//
module cartridge_bank_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cbc_pkg::in_item_t                in_item,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output cbc_pkg::out_item_t               out_item,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbc_pkg::CfgAddrW-1:0]     paddr,
  input  logic [cbc_pkg::CfgDataW-1:0]     pwdata,
  output logic [cbc_pkg::CfgDataW-1:0]     prdata,
  output logic                             pready
);

  // Config register
  cbc_pkg::mapper_t mapper_r, mapper_nxt;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    mapper_nxt = mapper_r;
    if (cfg_wr && paddr[cbc_pkg::CfgAddrW-1:2] == cbc_pkg::CFG_IDX_MAPPER) begin
      mapper_nxt = cbc_pkg::mapper_t'(pwdata[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapper_r <= cbc_pkg::MAPPER_NONE;
    end else begin
      mapper_r <= mapper_nxt;
    end
  end

  assign prdata = (paddr[cbc_pkg::CfgAddrW-1:2] == cbc_pkg::CFG_IDX_MAPPER)
                  ? {{(cbc_pkg::CfgDataW-2){1'b0}}, mapper_r}
                  : '0;

  // Input register
  logic               s1_valid_r, s1_valid_nxt;
  cbc_pkg::in_item_t  s1_item_r;
  logic               in_acc;
  logic               advance;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  cbc_pkg::out_item_t out_item_r;
  cbc_pkg::out_item_t result;

  // s1 moves on when the result slot is empty or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_acc || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  cbc_bank_regs u_bank_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (s1_item_r),
    .mapper_type (mapper_r),
    .result      (result)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A new result only appears after an input-stage move
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result without a request");

  // A held request stays in the input stage
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost a request");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !advance)
    else $error("result overwritten under stall");

endmodule

// File: hdl/cbc_bank_regs.sv
// ----------------------------------------------------------------------------
// cbc_bank_regs
// Bank register file: decodes one bus write, updates state, forms the mapping.
// ----------------------------------------------------------------------------
module cbc_bank_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  cbc_pkg::in_item_t  item,
  input  cbc_pkg::mapper_t   mapper_type,
  output cbc_pkg::out_item_t result
);

  logic [7:0] low_rom_r,  low_rom_nxt;
  logic [1:0] high_rom_r, high_rom_nxt;
  logic [3:0] ram_bank_r, ram_bank_nxt;
  logic       ram_en_r,   ram_en_nxt;
  logic       mode_r,     mode_nxt;

  cbc_pkg::region_t region;
  logic [4:0] mbc1_lo;
  logic [6:0] mbc3_lo;

  assign region = cbc_pkg::region_t'(item.address[15:13]);

  // Next state for the write held in the input stage
  always_comb begin
    low_rom_nxt  = low_rom_r;
    high_rom_nxt = high_rom_r;
    ram_bank_nxt = ram_bank_r;
    ram_en_nxt   = ram_en_r;
    mode_nxt     = mode_r;
    case (region)
      cbc_pkg::REGION_RAM_EN: begin
        ram_en_nxt = (item.data[3:0] == cbc_pkg::RAM_EN_KEY);
      end
      cbc_pkg::REGION_ROM_LOW: begin
        case (mapper_type)
          cbc_pkg::MAPPER_MBC1: begin
            low_rom_nxt = (item.data[4:0] == 5'd0) ? cbc_pkg::LOW_BANK_RST
                                                   : {3'b000, item.data[4:0]};
          end
          cbc_pkg::MAPPER_MBC3: begin
            low_rom_nxt = (item.data[6:0] == 7'd0) ? cbc_pkg::LOW_BANK_RST
                                                   : {1'b0, item.data[6:0]};
          end
          cbc_pkg::MAPPER_MBC5: begin
            // 0x3000 and up carries the ninth bank bit
            if (!item.address[12]) begin
              low_rom_nxt = item.data;
            end else begin
              high_rom_nxt = {1'b0, item.data[0]};
            end
          end
          default: begin
          end
        endcase
      end
      cbc_pkg::REGION_RAM_BANK: begin
        case (mapper_type)
          cbc_pkg::MAPPER_MBC1: begin
            if (mode_r) begin
              ram_bank_nxt = {2'b00, item.data[1:0]};
            end else begin
              high_rom_nxt = item.data[1:0];
            end
          end
          cbc_pkg::MAPPER_MBC3, cbc_pkg::MAPPER_MBC5: begin
            ram_bank_nxt = item.data[3:0];
          end
          default: begin
          end
        endcase
      end
      cbc_pkg::REGION_MODE: begin
        mode_nxt = item.data[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_rom_r  <= cbc_pkg::LOW_BANK_RST;
      high_rom_r <= 2'b00;
      ram_bank_r <= 4'h0;
      ram_en_r   <= 1'b0;
      mode_r     <= 1'b0;
    end else if (advance) begin
      low_rom_r  <= low_rom_nxt;
      high_rom_r <= high_rom_nxt;
      ram_bank_r <= ram_bank_nxt;
      ram_en_r   <= ram_en_nxt;
      mode_r     <= mode_nxt;
    end
  end

  // Mapping after the write; stale low bits masked to the mapper's width
  assign mbc1_lo = (low_rom_nxt[4:0] == 5'd0) ? 5'd1 : low_rom_nxt[4:0];
  assign mbc3_lo = (low_rom_nxt[6:0] == 7'd0) ? 7'd1 : low_rom_nxt[6:0];

  always_comb begin
    case (mapper_type)
      cbc_pkg::MAPPER_MBC1: result.rom_bank = {2'b00, high_rom_nxt, mbc1_lo};
      cbc_pkg::MAPPER_MBC3: result.rom_bank = {2'b00, mbc3_lo};
      cbc_pkg::MAPPER_MBC5: result.rom_bank = {high_rom_nxt[0], low_rom_nxt};
      default:              result.rom_bank = 9'd1;
    endcase
    result.ram_bank    = ram_bank_nxt;
    result.ram_enabled = ram_en_nxt;
    result.bank_mode   = mode_nxt;
  end

  // MBC1/MBC3 never map bank 0 into the switchable window
  a_no_bank0: assert property (@(posedge clk) disable iff (!rst_n)
    (mapper_type == cbc_pkg::MAPPER_MBC1 || mapper_type == cbc_pkg::MAPPER_MBC3)
    |-> result.rom_bank != 9'd0)
    else $error("bank 0 mapped for MBC1/MBC3");

  a_none_bank1: assert property (@(posedge clk) disable iff (!rst_n)
    (mapper_type == cbc_pkg::MAPPER_NONE) |-> result.rom_bank == 9'd1)
    else $error("no-mapper rom bank not 1");

  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && region == cbc_pkg::REGION_MODE) |=> mode_r == $past(item.data[0]))
    else $error("mode write lost");

endmodule

// File: sim/bank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_checker
// Watches the request, result and config channels of the bank controller,
// keeps its own copy of the bank registers and compares every result.
// ----------------------------------------------------------------------------
module bank_checker
  import cbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output int                  fail_count,
  output int                  pending
);

  localparam logic [CfgAddrW-1:0] MAPPER_ADDR = {CFG_IDX_MAPPER, 2'b00};

  // predicted controller state
  mapper_t   mapper;
  logic [7:0] low_bank;
  logic [1:0] high_bank;
  logic [3:0] ram_bank;
  logic       ram_en;
  logic       mode;

  out_item_t  mapping_q[$];
  out_item_t  want;
  logic [4:0] lo5;
  logic [6:0] lo7;
  int         errors = 0;

  task automatic check_field(input string name, input logic [8:0] exp_v,
                             input logic [8:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mapper    = MAPPER_NONE;
      low_bank  = LOW_BANK_RST;
      high_bank = '0;
      ram_bank  = '0;
      ram_en    = 1'b0;
      mode      = 1'b0;
      mapping_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAPPER_ADDR)
        mapper = mapper_t'(pwdata[1:0]);

      if (out_valid && !out_stall) begin
        if (mapping_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: rom %0d ram %0d en %0b mode %0b",
                   $time, out_item.rom_bank, out_item.ram_bank,
                   out_item.ram_enabled, out_item.bank_mode);
        end else begin
          want = mapping_q.pop_front();
          check_field("rom_bank", want.rom_bank, out_item.rom_bank);
          check_field("ram_bank", 9'(want.ram_bank), 9'(out_item.ram_bank));
          check_field("ram_enabled", 9'(want.ram_enabled), 9'(out_item.ram_enabled));
          check_field("bank_mode", 9'(want.bank_mode), 9'(out_item.bank_mode));
        end
      end

      if (in_valid && !in_stall) begin
        case (region_t'(in_item.address[15:13]))
          REGION_RAM_EN: ram_en = (in_item.data[3:0] == RAM_EN_KEY);
          REGION_ROM_LOW: begin
            case (mapper)
              MAPPER_MBC1: begin
                low_bank = {3'b000, in_item.data[4:0]};
                if (low_bank == 8'h00) low_bank = LOW_BANK_RST;
              end
              MAPPER_MBC3: begin
                low_bank = {1'b0, in_item.data[6:0]};
                if (low_bank == 8'h00) low_bank = LOW_BANK_RST;
              end
              MAPPER_MBC5: begin
                if (in_item.address < 16'h3000) low_bank = in_item.data;
                else high_bank = {1'b0, in_item.data[0]};
              end
              default: ;
            endcase
          end
          REGION_RAM_BANK: begin
            case (mapper)
              MAPPER_MBC1: begin
                if (mode) ram_bank = {2'b00, in_item.data[1:0]};
                else high_bank = in_item.data[1:0];
              end
              MAPPER_MBC3, MAPPER_MBC5: ram_bank = in_item.data[3:0];
              default: ;
            endcase
          end
          REGION_MODE: mode = in_item.data[0];
          default: ;
        endcase

        // stale low bits are masked to the current mapper; zero maps to 1
        case (mapper)
          MAPPER_MBC1: begin
            lo5 = low_bank[4:0];
            if (lo5 == 5'd0) lo5 = 5'd1;
            want.rom_bank = {2'b00, high_bank, lo5};
          end
          MAPPER_MBC3: begin
            lo7 = low_bank[6:0];
            if (lo7 == 7'd0) lo7 = 7'd1;
            want.rom_bank = {2'b00, lo7};
          end
          MAPPER_MBC5: want.rom_bank = {high_bank[0], low_bank};
          default:     want.rom_bank = 9'd1;
        endcase
        want.ram_bank    = ram_bank;
        want.ram_enabled = ram_en;
        want.bank_mode   = mode;
        mapping_q.push_back(want);
      end
    end
    pending    <= mapping_q.size();
    fail_count <= errors;
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives bus-write requests and mapper settings into the bank controller
// under several idle/stall mixes; bank_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import cbc_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASE_REQUESTS = 235;
  localparam int NUM_PHASES     = 8;
  // second slot of the register map; nothing lives there
  localparam logic [CfgAddrW-1:0] SPARE_REG_ADDR = {1'b1, 2'b00};
  localparam logic [CfgAddrW-1:0] MAPPER_ADDR    = {CFG_IDX_MAPPER, 2'b00};

  // boundary addresses of every decode window, plus both ends of the bus
  localparam logic [15:0] EDGE_ADDR [12] = '{
    16'h0000, 16'h1FFF, 16'h2000, 16'h2FFF, 16'h3000, 16'h3FFF,
    16'h4000, 16'h5FFF, 16'h6000, 16'h7FFF, 16'h8000, 16'hFFFF
  };

  // mapper per random phase; both extremes appear, and every mapper is
  // entered from another so stale bank bits get exercised
  localparam mapper_t PHASE_MAPPER [NUM_PHASES] = '{
    MAPPER_MBC1, MAPPER_MBC3, MAPPER_MBC5, MAPPER_NONE,
    MAPPER_MBC5, MAPPER_MBC1, MAPPER_MBC3, MAPPER_MBC1
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int fail_count;
  int pending;
  int cycles = 0;

  // percent chance per cycle that the sender idles / the receiver stalls
  int idle_pct  = 0;
  int stall_pct = 0;

  always #4 clk = ~clk;

  cartridge_bank_controller u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  bank_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Receiver back-pressure, redrawn every cycle from the current mix.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Issue one request. Entered right after a rising edge; returns right
  // after the edge at which the request was taken. Valid is only lowered
  // when a gap is drawn, so back-to-back requests keep it high.
  task automatic send_req(input in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every predicted mapping has come back.
  // The first edge lets the checker's pending count catch up with the
  // request accepted at the edge we entered on.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_cfg(input logic [CfgAddrW-1:0] addr,
                           input logic [CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mapper changes only with the pipeline empty.
  task automatic set_mapper(input mapper_t m);
    drain();
    write_cfg(MAPPER_ADDR, CfgDataW'(m));
  endtask

  // Random bus write: mostly inside the controller's window, some at the
  // window edges, some anywhere on the bus. Data is biased toward the RAM
  // enable key and toward a zero bank field so those paths come up often.
  function automatic in_item_t random_req();
    in_item_t r;
    int pick;
    pick   = $urandom_range(99);
    r.data = 8'($urandom_range(255));
    if (pick < 15) r.address = 16'($urandom_range(16'hFFFF));
    else if (pick < 25) r.address = EDGE_ADDR[$urandom_range(11)];
    else r.address = 16'($urandom_range(16'h7FFF));
    if ($urandom_range(3) == 0) r.data[3:0] = RAM_EN_KEY;
    if ($urandom_range(7) == 0) r.data[4:0] = 5'd0;
    return r;
  endfunction

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed requests ------------------------------------------------
    // No mapper (reset state): enable and mode still respond, bank writes are
    // dropped, writes above 0x7FFF change nothing.
    send_req({16'h0000, 8'h0A});
    send_req({16'h2000, 8'h05});
    send_req({16'h4000, 8'h03});
    send_req({16'h6000, 8'h01});
    send_req({16'hFFFF, 8'hFF});

    // MBC1, entered in mode 1: RAM bank select, bank 0 and 0x20 fold to 1,
    // then mode 0 routes the 0x4000 window to the upper ROM bits.
    set_mapper(MAPPER_MBC1);
    write_cfg(SPARE_REG_ADDR, 32'hFFFF_FFFF);   // unmapped register, ignored
    send_req({16'h1FFF, 8'hFA});
    send_req({16'h2000, 8'h00});
    send_req({16'h3FFF, 8'h20});
    send_req({16'h4000, 8'h03});
    send_req({16'h6000, 8'h00});
    send_req({16'h5FFF, 8'h02});
    send_req({16'h2000, 8'hFF});
    send_req({16'h7FFF, 8'hFE});

    // MBC3: 7-bit bank where 0x80 masks to zero and reads as 1, 4-bit RAM
    // bank regardless of mode, a near-miss on the enable key.
    set_mapper(MAPPER_MBC3);
    send_req({16'h2000, 8'h80});
    send_req({16'h2000, 8'h7F});
    send_req({16'h4000, 8'h0F});
    send_req({16'h0000, 8'h0B});

    // MBC5: bank 0 is legal, ninth bank bit lives at 0x3000-0x3FFF.
    set_mapper(MAPPER_MBC5);
    send_req({16'h2000, 8'h00});
    send_req({16'h2FFF, 8'hFF});
    send_req({16'h3000, 8'h01});
    send_req({16'h3FFF, 8'hFE});
    send_req({16'h4000, 8'hFF});
    send_req({16'h8000, 8'h55});

    // ---- random phases ----------------------------------------------------
    // Idle mixes rotate: none, sender mostly idle, receiver mostly stalled,
    // light idling on both. Each mapper change drains the pipe first.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mapper(PHASE_MAPPER[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (int i = 0; i < PHASE_REQUESTS; i++) send_req(random_req());
    end

    drain();
    stall_pct = 0;
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/cbc_pkg.sv
hdl/cbc_bank_regs.sv
hdl/cartridge_bank_controller.sv
sim/bank_checker.sv
sim/tb_top.sv
